[rtl/core/salic_pkg.sv]
`timescale 1ns / 1ps
// shared types, geometry constants and codes for the instruction cache
// no dependencies
package salic_pkg;

    localparam int LINE_BYTES = 16;
    localparam int WAYS       = 4;
    localparam int SETS       = 64;
    localparam int SPM_BYTES  = 1048576;

    localparam int ADDR_W = 64;
    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int SPM_W  = $clog2(SPM_BYTES);
    localparam int LINE_W = SPM_W - OFF_W;
    localparam int SET_W  = $clog2(SETS);
    localparam int TAG_W  = LINE_W - SET_W;
    localparam int WAY_W  = $clog2(WAYS);

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_ALIGN = 2'd2;

    localparam logic KIND_FETCH = 1'b0;
    localparam logic KIND_INVAL = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] fetch_address;
        logic [2:0]        fetch_size;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [1:0]  error_code;
        logic [1:0]  fill_count;
        logic [19:0] first_fill_offset;
        logic [19:0] second_fill_offset;
        logic [5:0]  fill_bytes;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_FETCH,
        CMD_INVAL,
        CMD_ERROR
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [1:0]        err_code;
        logic [LINE_W-1:0] first_line;
        logic              two_lines;
    } cmd_t;

    typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;
    typedef logic [WAYS-1:0][WAY_W-1:0] rank_row_t;

endpackage

[rtl/core/salic_front.sv]
`timescale 1ns / 1ps
// front end: holds the window base, checks and classifies each input transfer
// depends on salic_pkg
module salic_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [63:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  salic_pkg::in_item_t    in_data,
    output logic                   push,
    output salic_pkg::cmd_t        cmd,
    input  logic                   q_full
);

    logic [63:0]                  spm_base_reg;
    logic [63:0]                  rel;
    logic                         below;
    logic                         size_ok;
    logic [salic_pkg::SPM_W:0]    end_sum;
    logic                         in_window;
    logic [salic_pkg::OFF_W:0]    span;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign push      = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spm_base_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            spm_base_reg <= cfg_data;
        end
    end

    always_comb
    begin
        rel       = in_data.fetch_address - spm_base_reg;
        below     = in_data.fetch_address < spm_base_reg;
        size_ok   = (in_data.fetch_size == 3'd2) || (in_data.fetch_size == 3'd4);
        end_sum   = {1'b0, rel[salic_pkg::SPM_W-1:0]}
                  + (salic_pkg::SPM_W+1)'(in_data.fetch_size);
        in_window = !below && (rel[63:salic_pkg::SPM_W] == '0)
                  && (end_sum <= (salic_pkg::SPM_W+1)'(salic_pkg::SPM_BYTES));
        span      = {1'b0, rel[salic_pkg::OFF_W-1:0]}
                  + (salic_pkg::OFF_W+1)'(in_data.fetch_size)
                  - (salic_pkg::OFF_W+1)'(1);

        cmd            = '0;
        cmd.first_line = rel[salic_pkg::SPM_W-1:salic_pkg::OFF_W];
        cmd.two_lines  = span[salic_pkg::OFF_W];
        if (in_data.kind == salic_pkg::KIND_INVAL)
        begin
            cmd.op = salic_pkg::CMD_INVAL;
        end
        else if (!size_ok || !in_window)
        begin
            cmd.op       = salic_pkg::CMD_ERROR;
            cmd.err_code = salic_pkg::ERR_RANGE;
        end
        else if (in_data.fetch_address[0])
        begin
            cmd.op       = salic_pkg::CMD_ERROR;
            cmd.err_code = salic_pkg::ERR_ALIGN;
        end
        else
        begin
            cmd.op       = salic_pkg::CMD_FETCH;
            cmd.err_code = salic_pkg::ERR_NONE;
        end
    end

endmodule

[rtl/core/salic_queue.sv]
`timescale 1ns / 1ps
// two-entry command queue between the front and back ends
// depends on salic_pkg
module salic_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  salic_pkg::cmd_t   push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output salic_pkg::cmd_t   head
);

    salic_pkg::cmd_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[rtl/core/salic_back.sv]
`timescale 1ns / 1ps
// back end: tag lookup, lru update, line fill and result register
// depends on salic_pkg
module salic_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  salic_pkg::cmd_t       head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output salic_pkg::out_item_t  out_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_HOLD
    } state_t;

    state_t                          state_reg;
    logic [salic_pkg::LINE_W-1:0]    cur_line_reg;
    logic                            second_reg;
    logic                            all_hit_reg;
    logic [1:0]                      count_reg;
    logic [19:0]                     off0_reg;
    logic [19:0]                     off1_reg;
    logic [1:0]                      err_reg;
    logic                            out_valid_reg;
    salic_pkg::out_item_t            out_data_reg;
    logic [salic_pkg::WAYS-1:0]      valid_reg [salic_pkg::SETS];
    logic [salic_pkg::SETS-1:0]      rank_ok_reg;

    salic_pkg::tag_row_t             tag_mem [salic_pkg::SETS];
    salic_pkg::rank_row_t            rank_mem [salic_pkg::SETS];
    salic_pkg::tag_row_t             tag_q;
    salic_pkg::rank_row_t            rank_q;

    logic                            rd_en;
    logic [salic_pkg::SET_W-1:0]     rd_set;
    logic [salic_pkg::SET_W-1:0]     cur_set;
    logic [salic_pkg::TAG_W-1:0]     cur_tag;
    logic [salic_pkg::WAYS-1:0]      vld;
    salic_pkg::rank_row_t            ranks;
    salic_pkg::rank_row_t            ranks_new;
    salic_pkg::tag_row_t             tags_new;
    logic                            is_hit;
    logic                            found;
    logic [salic_pkg::WAY_W-1:0]     way;
    logic [salic_pkg::WAY_W-1:0]     old_rank;
    logic                            upd;
    logic                            hit_next;
    logic [1:0]                      count_next;
    logic [19:0]                     off0_next;
    logic [19:0]                     off1_next;
    logic                            out_free;
    logic                            load_out;
    salic_pkg::out_item_t            res_next;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = out_free && (((state_reg == ST_UPDATE) && !second_reg)
                                    || (state_reg == ST_HOLD));
    assign pop       = (state_reg == ST_IDLE) && !q_empty;
    assign upd       = state_reg == ST_UPDATE;
    assign rd_en     = (pop && (head.op == salic_pkg::CMD_FETCH)) || (state_reg == ST_READ);
    assign rd_set    = (state_reg == ST_IDLE) ? head.first_line[salic_pkg::SET_W-1:0]
                                              : cur_line_reg[salic_pkg::SET_W-1:0];
    assign cur_set   = cur_line_reg[salic_pkg::SET_W-1:0];
    assign cur_tag   = cur_line_reg[salic_pkg::LINE_W-1:salic_pkg::SET_W];

    // lookup, victim choice and true-lru rank update for the current line
    always_comb
    begin
        vld = valid_reg[cur_set];
        for (int w = 0; w < salic_pkg::WAYS; w++)
        begin
            ranks[w] = rank_ok_reg[cur_set] ? rank_q[w] : salic_pkg::WAY_W'(w);
        end
        is_hit = 1'b0;
        way    = '0;
        for (int w = salic_pkg::WAYS - 1; w >= 0; w--)
        begin
            if (vld[w] && (tag_q[w] == cur_tag))
            begin
                is_hit = 1'b1;
                way    = salic_pkg::WAY_W'(w);
            end
        end
        if (!is_hit)
        begin
            found = 1'b0;
            for (int w = salic_pkg::WAYS - 1; w >= 0; w--)
            begin
                if (!vld[w])
                begin
                    found = 1'b1;
                    way   = salic_pkg::WAY_W'(w);
                end
            end
            if (!found)
            begin
                for (int w = salic_pkg::WAYS - 1; w >= 0; w--)
                begin
                    if (ranks[w] == '0)
                    begin
                        way = salic_pkg::WAY_W'(w);
                    end
                end
            end
        end
        else
        begin
            found = 1'b0;
        end
        old_rank = ranks[way];
        for (int w = 0; w < salic_pkg::WAYS; w++)
        begin
            ranks_new[w] = (ranks[w] > old_rank) ? ranks[w] - salic_pkg::WAY_W'(1) : ranks[w];
        end
        ranks_new[way] = salic_pkg::WAY_W'(salic_pkg::WAYS - 1);
        tags_new       = tag_q;
        tags_new[way]  = cur_tag;

        hit_next   = all_hit_reg && is_hit;
        count_next = is_hit ? count_reg : count_reg + 2'd1;
        off0_next  = off0_reg;
        off1_next  = off1_reg;
        if (!is_hit && (count_reg == 2'd0))
        begin
            off0_next = {cur_line_reg, {salic_pkg::OFF_W{1'b0}}};
        end
        else if (!is_hit && (count_reg == 2'd1))
        begin
            off1_next = {cur_line_reg, {salic_pkg::OFF_W{1'b0}}};
        end

        res_next                    = '0;
        res_next.hit                = hit_next;
        res_next.error_code         = salic_pkg::ERR_NONE;
        res_next.fill_count         = count_next;
        res_next.first_fill_offset  = off0_next;
        res_next.second_fill_offset = off1_next;
        res_next.fill_bytes         = 6'({count_next, {salic_pkg::OFF_W{1'b0}}});
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            tag_q  <= tag_mem[rd_set];
            rank_q <= rank_mem[rd_set];
        end
        if (upd)
        begin
            rank_mem[cur_set] <= ranks_new;
            if (!is_hit)
            begin
                tag_mem[cur_set] <= tags_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            rank_ok_reg   <= '0;
            second_reg    <= 1'b0;
            cur_line_reg  <= '0;
            all_hit_reg   <= 1'b0;
            count_reg     <= 2'd0;
            off0_reg      <= '0;
            off1_reg      <= '0;
            err_reg       <= salic_pkg::ERR_NONE;
            for (int s = 0; s < salic_pkg::SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= load_out || (out_valid_reg && out_stall);
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        cur_line_reg <= head.first_line;
                        second_reg   <= head.two_lines && (head.op == salic_pkg::CMD_FETCH);
                        all_hit_reg  <= 1'b1;
                        count_reg    <= 2'd0;
                        off0_reg     <= '0;
                        off1_reg     <= '0;
                        err_reg      <= head.err_code;
                        case (head.op)
                            salic_pkg::CMD_FETCH:
                            begin
                                state_reg <= ST_UPDATE;
                            end
                            salic_pkg::CMD_INVAL:
                            begin
                                for (int s = 0; s < salic_pkg::SETS; s++)
                                begin
                                    valid_reg[s] <= '0;
                                end
                                all_hit_reg <= 1'b0;
                                err_reg     <= salic_pkg::ERR_NONE;
                                state_reg   <= ST_HOLD;
                            end
                            default:
                            begin
                                all_hit_reg <= 1'b0;
                                state_reg   <= ST_HOLD;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    rank_ok_reg[cur_set] <= 1'b1;
                    if (!is_hit)
                    begin
                        valid_reg[cur_set][way] <= 1'b1;
                    end
                    all_hit_reg <= hit_next;
                    count_reg   <= count_next;
                    off0_reg    <= off0_next;
                    off1_reg    <= off1_next;
                    err_reg     <= salic_pkg::ERR_NONE;
                    if (second_reg)
                    begin
                        second_reg   <= 1'b0;
                        cur_line_reg <= cur_line_reg + salic_pkg::LINE_W'(1);
                        state_reg    <= ST_READ;
                    end
                    else if (out_free)
                    begin
                        out_data_reg  <= res_next;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        out_data_reg.hit                <= all_hit_reg;
                        out_data_reg.error_code         <= err_reg;
                        out_data_reg.fill_count         <= count_reg;
                        out_data_reg.first_fill_offset  <= off0_reg;
                        out_data_reg.second_fill_offset <= off1_reg;
                        out_data_reg.fill_bytes         <=
                            6'({count_reg, {salic_pkg::OFF_W{1'b0}}});
                        state_reg                       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE))
        else $error("queue pop outside idle");

    a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.hit && (out_data_reg.fill_count != 2'd0)))
        else $error("hit result reports a fill");

    a_err_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.error_code != salic_pkg::ERR_NONE))
        |-> ((out_data_reg.fill_count == 2'd0) && !out_data_reg.hit))
        else $error("error result carries fill data");

    a_update_filled: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && !is_hit) |=> valid_reg[$past(cur_set)][$past(way)])
        else $error("filled way not marked valid");

endmodule

[rtl/core/set_assoc_lru_instruction_cache.sv]
`timescale 1ns / 1ps
// top level of the set-associative true-lru instruction cache
// depends on salic_pkg, salic_front, salic_queue, salic_back
//
// usage:
//   in_valid/in_stall/in_data carry fetch or invalidate items; a transfer
//   happens when in_valid is high and in_stall is low. out_valid/out_stall/
//   out_data return one result per item, in order. cfg_valid/cfg_ready/
//   cfg_data write the window base; cfg_ready is always high and the user must
//   make writes only while the cache is idle; the block does not enforce it.
//   the front end checks size, window and alignment in the transfer cycle and
//   queues a command (two entries). the back end takes one command at a time:
//   error and invalidate commands pass from idle through the hold state; a fetch
//   goes from idle to the update state and, when it crosses into a second line,
//   through the read and update states once more, each line's update following
//   the registered read of the tag and rank memories.
//   while out_stall is high the result holds, the back end waits, and the
//   queue fills until in_stall rises.
//   reset clears the window base and all valid bits at once and marks all lru
//   ranks unset, so they read as way order; no clearing pass is needed.
module set_assoc_lru_instruction_cache (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [63:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  salic_pkg::in_item_t   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output salic_pkg::out_item_t  out_data
);

    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    salic_pkg::cmd_t push_cmd;
    salic_pkg::cmd_t head;

    salic_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .push      (push),
        .cmd       (push_cmd),
        .q_full    (q_full)
    );

    salic_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    salic_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
